// File: hdl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime factor: shared package
// Holds the sequencer state type used by the top level.
// ----------------------------------------------------------------------------
package tdpf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_TEST,
		ST_DIV,
		ST_CHECK
	} tdpf_state_t;

endpackage

// File: hdl/trial_division_prime_factor_top.sv
// ----------------------------------------------------------------------------
// Trial division prime factor: top level
// Decides by trial division whether a number is prime and reports its
// smallest factor above one and the matching cofactor.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                  Handshake
//  --------  ---------------------------------------  ------------------------
//  request   start, number                            taken when start & !busy
//  result    done, is_prime, smallest_factor,         done high for one cycle
//            cofactor
//
// A number below two or an even number is answered from the first state
// without the divider. An odd number tries odd divisors from three upward,
// each costing one square compare, NUMBER_BITS restoring divide steps and
// one remainder check, and one more square compare when it turns out prime.
// The single shift-subtract divider serves every odd divisor tried.
// Reset returns the sequencer to idle and clears the result strobe.
// The receiver cannot stall: each result is shown for exactly one cycle,
// and the next request may be taken in that same cycle.
module trial_division_prime_factor_top #(
	parameter int NUMBER_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   done,
	output logic                   is_prime,
	output logic [NUMBER_BITS-1:0] smallest_factor,
	output logic [NUMBER_BITS-1:0] cofactor
);
	import tdpf_pkg::*;

	localparam int NB    = NUMBER_BITS;
	// The running square never exceeds 2^(NB+2) before the loop stops.
	localparam int SQ_W  = NB + 2;
	localparam int CNT_W = $clog2(NB);

	tdpf_state_t state_q, state_d;

	// Number under test, current odd divisor and its square.
	logic [NB-1:0]    num_q;
	logic [NB-1:0]    div_q;
	logic [SQ_W-1:0]  sq_q;

	// Restoring divider: partial remainder, dividend/quotient shift register
	// and the step counter.
	logic [NB-1:0]    rem_q;
	logic [NB-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [NB+1:0]    trial_diff;
	logic             trial_borrow;
	logic [NB-1:0]    rem_step;
	logic [NB-1:0]    quo_step;

	// Controls from the output decoder.
	logic             emit;
	logic             emit_prime;
	logic [NB-1:0]    emit_factor;
	logic [NB-1:0]    emit_cofactor;
	logic             init_odd;
	logic             load_div;
	logic             step_div;
	logic             next_divisor;

	logic             num_small;
	logic             sq_over;

	assign num_small = (num_q < NB'(2));
	assign sq_over   = (sq_q > {2'b00, num_q});

	// One divide step: shift the next dividend bit into the remainder and
	// subtract the divisor if it fits.
	assign trial_diff   = {1'b0, rem_q, quo_q[NB-1]} - {2'b00, div_q};
	assign trial_borrow = trial_diff[NB+1];
	assign rem_step     = trial_borrow ? {rem_q[NB-2:0], quo_q[NB-1]} : trial_diff[NB-1:0];
	assign quo_step     = {quo_q[NB-2:0], ~trial_borrow};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_FIRST;
			end
			ST_FIRST: begin
				if (num_small || !num_q[0]) state_d = ST_IDLE;
				else                        state_d = ST_TEST;
			end
			ST_TEST: begin
				if (sq_over) state_d = ST_IDLE;
				else         state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (rem_q == '0) state_d = ST_IDLE;
				else             state_d = ST_TEST;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output and datapath control decoding.
	always_comb begin
		emit          = 1'b0;
		emit_prime    = 1'b0;
		emit_factor   = '0;
		emit_cofactor = '0;
		init_odd      = 1'b0;
		load_div      = 1'b0;
		step_div      = 1'b0;
		next_divisor  = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_FIRST: begin
				if (num_small) begin
					// Zero and one are not prime and have no factor.
					emit = 1'b1;
				end else if (!num_q[0]) begin
					// Even: two divides it; two itself is the only even prime.
					emit          = 1'b1;
					emit_prime    = (num_q == NB'(2));
					emit_factor   = NB'(2);
					emit_cofactor = num_q >> 1;
				end else begin
					init_odd = 1'b1;
				end
			end
			ST_TEST: begin
				if (sq_over) begin
					// No divisor up to the square root: prime.
					emit          = 1'b1;
					emit_prime    = 1'b1;
					emit_factor   = num_q;
					emit_cofactor = NB'(1);
				end else begin
					load_div = 1'b1;
				end
			end
			ST_DIV: begin
				step_div = 1'b1;
			end
			ST_CHECK: begin
				if (rem_q == '0) begin
					emit          = 1'b1;
					emit_factor   = div_q;
					emit_cofactor = quo_q;
				end else begin
					next_divisor = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) num_q <= number;
		if (init_odd) begin
			div_q <= NB'(3);
			sq_q  <= SQ_W'(9);
		end else if (next_divisor) begin
			// (d + 2)^2 = d^2 + 4d + 4
			div_q <= div_q + NB'(2);
			sq_q  <= sq_q + {div_q, 2'b00} + SQ_W'(4);
		end
		if (load_div) begin
			rem_q <= '0;
			quo_q <= num_q;
			cnt_q <= CNT_W'(NB - 1);
		end else if (step_div) begin
			rem_q <= rem_step;
			quo_q <= quo_step;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (emit) begin
			is_prime        <= emit_prime;
			smallest_factor <= emit_factor;
			cofactor        <= emit_cofactor;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: hdl/tdpf_checker.sv
// ----------------------------------------------------------------------------
// Trial division prime factor: port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module tdpf_checker #(
	parameter int NUMBER_BITS = 10
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   is_prime,
	input logic [NUMBER_BITS-1:0] smallest_factor,
	input logic [NUMBER_BITS-1:0] cofactor
);

	// A request that is taken makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// A result only follows work, and the block is free when it is shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe without preceding work");

	// A prime reports one as cofactor and a factor of at least two.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && is_prime |-> cofactor == NUMBER_BITS'(1) && smallest_factor >= NUMBER_BITS'(2))
		else $error("prime result malformed");

	// The smallest factor of a composite never exceeds its cofactor.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_prime && smallest_factor != '0 |-> smallest_factor <= cofactor
		|| cofactor == NUMBER_BITS'(1))
		else $error("smallest factor exceeds cofactor");

endmodule

bind trial_division_prime_factor_top tdpf_checker #(
	.NUMBER_BITS(NUMBER_BITS)
) u_tdpf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.is_prime       (is_prime),
	.smallest_factor(smallest_factor),
	.cofactor       (cofactor)
);

// File: test/tb_trial_division_prime_factor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime factor: regression testbench
// Sends numbers to the block and checks the prime flag, the smallest factor
// and the cofactor of every result against an independent trial division
// predictor. The run covers directed corner numbers, random numbers biased
// toward odd values and odd composites, a full drain pause, and a stretch of
// back-to-back requests.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_factor_top;

	localparam int NUMBER_BITS = 10;
	localparam int unsigned MAX_NUMBER = (1 << NUMBER_BITS) - 1;

	// The limit lies far above the longest run for the worst odd number and
	// the longest idle burst of the sender, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;

	// Cycles to keep watching after the last result, to catch stray strobes.
	localparam int TAIL_CYCLES = 8;

	// One expected result, kept together with the number that caused it so
	// that a mismatch line can name the request.
	typedef struct {
		logic [NUMBER_BITS-1:0] number;
		logic                   is_prime;
		logic [NUMBER_BITS-1:0] smallest_factor;
		logic [NUMBER_BITS-1:0] cofactor;
	} factor_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [NUMBER_BITS-1:0] number = '0;
	logic                   busy;
	logic                   done;
	logic                   is_prime;
	logic [NUMBER_BITS-1:0] smallest_factor;
	logic [NUMBER_BITS-1:0] cofactor;

	factor_result_t pending_factors[$];
	int             mismatch_count = 0;
	int             quiet_cycles = 0;

	// Odd primes up to the square root of the largest 10-bit number. Their
	// multiples force the divisor loop to run to a chosen depth.
	int unsigned odd_primes[10] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

	trial_division_prime_factor_top #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.number(number),
		.done(done),
		.is_prime(is_prime),
		.smallest_factor(smallest_factor),
		.cofactor(cofactor)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor: plain trial division. Even numbers stop at two, odd ones try
	// 3, 5, 7, ... while the divisor squared does not pass the number. A
	// number below two has no factor and reports all zeros.
	// ------------------------------------------------------------------------
	function automatic factor_result_t predict_factors(input logic [NUMBER_BITS-1:0] n);
		factor_result_t r;
		int unsigned    value;
		int unsigned    divisor;
		int unsigned    least;
		value = n;
		r.number = n;
		if (value < 2) begin
			r.is_prime = 1'b0;
			r.smallest_factor = '0;
			r.cofactor = '0;
		end else begin
			least = value;
			if (value % 2 == 0) begin
				least = 2;
			end else begin
				for (divisor = 3; divisor * divisor <= value && least == value;
						divisor += 2) begin
					if (value % divisor == 0)
						least = divisor;
				end
			end
			// A number that is its own least divisor is prime; the divisor
			// of two itself lands here too, giving factor two and cofactor one.
			r.is_prime = (least == value);
			r.smallest_factor = NUMBER_BITS'(least);
			r.cofactor = NUMBER_BITS'(value / least);
		end
		return r;
	endfunction

	// A random number drawn from one of three shapes: anything in range, an
	// odd number (which enters the divisor loop unless it is one), or an odd
	// multiple of a small odd prime (which leaves the loop at its least prime
	// factor, or runs it to the end when the multiple is one and it is prime).
	function automatic logic [NUMBER_BITS-1:0] pick_number();
		int unsigned p;
		int unsigned q;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return NUMBER_BITS'($urandom_range(0, MAX_NUMBER));
			4, 5, 6: return NUMBER_BITS'(2 * $urandom_range(0, MAX_NUMBER / 2) + 1);
			default: begin
				p = odd_primes[$urandom_range(0, 9)];
				q = 2 * $urandom_range(0, (MAX_NUMBER / p - 1) / 2) + 1;
				return NUMBER_BITS'(p * q);
			end
		endcase
	endfunction

	task automatic report_mismatch(input factor_result_t want, input string field,
			input int unsigned expected, input int unsigned got);
		$display("[%0t] mismatch for number %0d: %s expected %0d, got %0d",
			$realtime, want.number, field, expected, got);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Request and result monitor. At every rising edge it first retires a
	// result, if the strobe is up, against the oldest pending expectation,
	// and then records a newly accepted request. A result can never belong
	// to a request taken at the same edge, so this order is safe. The same
	// process runs the watchdog over cycles where nothing moves.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		factor_result_t want;
		logic           accepted;
		if (arst_n) begin
			accepted = start && !busy;
			if (done) begin
				if (pending_factors.size() == 0) begin
					want.number = '0;
					report_mismatch(want, "result with no request pending", 0,
						smallest_factor);
				end else begin
					want = pending_factors.pop_front();
					if (is_prime !== want.is_prime)
						report_mismatch(want, "is_prime", want.is_prime, is_prime);
					if (smallest_factor !== want.smallest_factor)
						report_mismatch(want, "smallest_factor", want.smallest_factor,
							smallest_factor);
					if (cofactor !== want.cofactor)
						report_mismatch(want, "cofactor", want.cofactor, cofactor);
				end
			end
			if (accepted)
				pending_factors.push_back(predict_factors(number));
			if (accepted || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no request or result for %0d cycles",
					$realtime, WATCHDOG_LIMIT);
				$display("trial_division_prime_factor_top regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender helpers. A request holds start high until an edge finds busy
	// low; start is left high on return so that a following request keeps
	// it up without a drop. Only the gap and drain helpers lower it.
	// ------------------------------------------------------------------------
	task automatic send_number(input logic [NUMBER_BITS-1:0] n);
		start <= 1'b1;
		number <= n;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Roughly one request in four is followed by a short idle burst.
	task automatic sender_gap();
		if ($urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every pending result has come back. The
	// first edge lets the monitor record a request taken at the last edge.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_factors.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corner numbers: zero and one, two and other evens, small primes, the
	// squares of primes (where the loop stops exactly at the square root),
	// the largest prime in range, and the all-ones and top-bit patterns.
	task automatic test_directed_cases();
		logic [NUMBER_BITS-1:0] corner_numbers[20];
		corner_numbers = '{0, 1, 2, 3, 4, 5, 9, 15, 25, 49, 121, 343, 841, 961,
			997, 1021, 1022, 1023, 512, 513};
		foreach (corner_numbers[i])
			send_number(corner_numbers[i]);
		drain_results();
	endtask

	// Random numbers with idle bursts on the request side.
	task automatic test_random_numbers(input int count);
		repeat (count) begin
			send_number(pick_number());
			sender_gap();
		end
	endtask

	// A burst of requests, then a full stop until everything has come back,
	// then more requests from an idle block.
	task automatic test_drain_pause();
		repeat (20) begin
			send_number(pick_number());
			sender_gap();
		end
		drain_results();
		repeat (10) begin
			send_number(pick_number());
			sender_gap();
		end
	endtask

	// No idling at all: each request is offered as soon as the last one is
	// taken, so new requests land in the cycle where a result is shown.
	task automatic test_back_to_back(input int count);
		repeat (count)
			send_number(pick_number());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_numbers(470);
		test_drain_pause();
		test_back_to_back(330);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("trial_division_prime_factor_top regression: pass");
		else
			$display("trial_division_prime_factor_top regression: fail");
		$finish;
	end

endmodule
